// ----- design/sprite_batch_texture_slot_binder_unit_assert.svh -----
// Assertion macros shared by the sprite batch texture slot binder RTL.
// Included by the modules that carry concurrent assertions; needs nothing else.
`ifndef SPRITE_BATCH_TEXTURE_SLOT_BINDER_UNIT_ASSERT_SVH
`define SPRITE_BATCH_TEXTURE_SLOT_BINDER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SBTSB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SBTSB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/sbtsb_pkg.sv -----
// Package of the sprite batch texture slot binder: item types, codes and defaults.
// Used by every module of the block but sbtsb_ram; depends on nothing.
package sbtsb_pkg;

  localparam int unsigned MAX_QUADS = 8192;
  localparam int unsigned MAX_SLOTS = 32;

  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  localparam logic KIND_QUAD  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // Register index taken from paddr bit 2.
  localparam logic REG_WHITE = 1'b0;

  typedef enum logic [2:0] {
    FUNC_BEGIN   = 3'd0,
    FUNC_UNTEX   = 3'd1,
    FUNC_TEX     = 3'd2,
    FUNC_END     = 3'd3,
    FUNC_CLR_STS = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_END_FLUSH,
    ST_QUAD_FLUSH,
    ST_SEARCH,
    ST_SLOT_FLUSH,
    ST_PLACE
  } state_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] texture_handle;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [4:0]  slot;
    logic [12:0] quad_position;
    logic [13:0] batch_quads;
    logic [5:0]  batch_slots;
    logic [31:0] draw_calls;
    logic [31:0] quads_total;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic      push;
    out_item_t item;
  } res_t;

endpackage

// ----- design/sbtsb_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stand-alone; no package dependency.
module sbtsb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/sbtsb_apb.sv -----
// Configuration register file of the slot binder behind an APB-style port.
// Depends on sbtsb_pkg for the register index code.
module sbtsb_apb (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] white_o
);

  logic [31:0] white_q;
  logic [31:0] white_d;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    white_d = white_q;
    if (wr_en && (paddr[2] == sbtsb_pkg::REG_WHITE)) begin
      white_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_q <= '0;
    end else begin
      white_q <= white_d;
    end
  end

  assign prdata  = (paddr[2] == sbtsb_pkg::REG_WHITE) ? white_q : '0;
  assign white_o = white_q;

endmodule

// ----- design/sbtsb_out.sv -----
// Output register of the slot binder that holds one result item for the receiver.
// Depends on sbtsb_pkg for the result types.
module sbtsb_out (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sbtsb_pkg::res_t       res_i,
  output logic                  free_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sbtsb_pkg::out_item_t  out_item_o
);

  logic                 valid_q;
  logic                 valid_d;
  sbtsb_pkg::out_item_t item_q;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (res_i.push) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.push) begin
      item_q <= res_i.item;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

// ----- design/sbtsb_ctrl.sv -----
// Batch control of the slot binder: command decode, slot table scan and counters.
// Depends on sbtsb_pkg, sbtsb_ram and the assertion macro header.
`include "sprite_batch_texture_slot_binder_unit_assert.svh"

module sbtsb_ctrl #(
  parameter int unsigned MaxQuads = sbtsb_pkg::MAX_QUADS,
  parameter int unsigned MaxSlots = sbtsb_pkg::MAX_SLOTS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sbtsb_pkg::in_item_t  in_item_i,
  input  logic [31:0]          white_i,
  input  logic                 out_free_i,
  output sbtsb_pkg::res_t      res_o
);

  localparam int unsigned AW = $clog2(MaxSlots);
  localparam int unsigned SW = $clog2(MaxSlots + 1);
  localparam int unsigned QW = $clog2(MaxQuads + 1);

  sbtsb_pkg::state_e state_q, state_d;

  logic          tex_q, tex_d;
  logic [31:0]   handle_q, handle_d;
  logic [AW-1:0] slot_q, slot_d;
  logic          append_q, append_d;
  logic [SW-1:0] issue_q, issue_d;
  logic          rd_vld_q, rd_vld_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  logic [SW-1:0] slots_used_q, slots_used_d;
  logic [QW-1:0] quad_count_q, quad_count_d;
  logic [31:0]   flush_cnt_q, flush_cnt_d;
  logic [31:0]   quad_cnt_q, quad_cnt_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  logic accept, qfull, white_hit, tbl_hit, can_issue, slots_full, batch_empty;
  logic [31:0] flush_inc, quad_inc;
  sbtsb_pkg::out_item_t flush_item, quad_item;

  sbtsb_ram #(
    .Width(32),
    .Depth(MaxSlots)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(handle_q),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o  = (state_q != sbtsb_pkg::ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign qfull       = (quad_count_q >= QW'(MaxQuads));
  assign white_hit   = (handle_q == white_i);
  assign tbl_hit     = rd_vld_q && (ram_rdata == handle_q);
  assign can_issue   = (issue_q < slots_used_q);
  assign slots_full  = (slots_used_q >= SW'(MaxSlots));
  assign batch_empty = (quad_count_q == '0);
  assign flush_inc   = (flush_cnt_q == sbtsb_pkg::CNT_MAX) ? flush_cnt_q : flush_cnt_q + 32'd1;
  assign quad_inc    = (quad_cnt_q == sbtsb_pkg::CNT_MAX) ? quad_cnt_q : quad_cnt_q + 32'd1;

  always_comb begin
    flush_item               = '0;
    flush_item.kind          = sbtsb_pkg::KIND_FLUSH;
    flush_item.batch_quads   = 14'(quad_count_q);
    flush_item.batch_slots   = 6'(slots_used_q);
    flush_item.draw_calls    = flush_inc;
    flush_item.quads_total   = quad_cnt_q;
    quad_item                = '0;
    quad_item.kind           = sbtsb_pkg::KIND_QUAD;
    quad_item.slot           = 5'(slot_q);
    quad_item.quad_position  = 13'(quad_count_q);
    quad_item.draw_calls     = flush_cnt_q;
    quad_item.quads_total    = quad_inc;
    quad_item.last           = 1'b1;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sbtsb_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_item_i.func)
            sbtsb_pkg::FUNC_END: begin
              if (!batch_empty) begin
                state_d = sbtsb_pkg::ST_END_FLUSH;
              end
            end
            sbtsb_pkg::FUNC_UNTEX, sbtsb_pkg::FUNC_TEX: begin
              if (qfull) begin
                state_d = sbtsb_pkg::ST_QUAD_FLUSH;
              end else if (in_item_i.func == sbtsb_pkg::FUNC_TEX) begin
                state_d = sbtsb_pkg::ST_SEARCH;
              end else begin
                state_d = sbtsb_pkg::ST_PLACE;
              end
            end
            default: state_d = sbtsb_pkg::ST_IDLE;
          endcase
        end
      end
      sbtsb_pkg::ST_END_FLUSH: begin
        if (out_free_i) begin
          state_d = sbtsb_pkg::ST_IDLE;
        end
      end
      sbtsb_pkg::ST_QUAD_FLUSH: begin
        if (out_free_i) begin
          state_d = tex_q ? sbtsb_pkg::ST_SEARCH : sbtsb_pkg::ST_PLACE;
        end
      end
      sbtsb_pkg::ST_SEARCH: begin
        priority if (white_hit || tbl_hit) begin
          state_d = sbtsb_pkg::ST_PLACE;
        end else if (can_issue || rd_vld_q) begin
          state_d = sbtsb_pkg::ST_SEARCH;
        end else if (slots_full) begin
          state_d = sbtsb_pkg::ST_SLOT_FLUSH;
        end else begin
          state_d = sbtsb_pkg::ST_PLACE;
        end
      end
      sbtsb_pkg::ST_SLOT_FLUSH: begin
        if (batch_empty || out_free_i) begin
          state_d = sbtsb_pkg::ST_PLACE;
        end
      end
      sbtsb_pkg::ST_PLACE: begin
        if (out_free_i) begin
          state_d = sbtsb_pkg::ST_IDLE;
        end
      end
      default: state_d = sbtsb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    tex_d        = tex_q;
    handle_d     = handle_q;
    slot_d       = slot_q;
    append_d     = append_q;
    issue_d      = issue_q;
    rd_vld_d     = rd_vld_q;
    rd_idx_d     = rd_idx_q;
    slots_used_d = slots_used_q;
    quad_count_d = quad_count_q;
    flush_cnt_d  = flush_cnt_q;
    quad_cnt_d   = quad_cnt_q;
    ram_we       = 1'b0;
    ram_waddr    = slot_q;
    ram_re       = 1'b0;
    ram_raddr    = issue_q[AW-1:0];
    res_o        = '0;

    unique case (state_q)
      sbtsb_pkg::ST_IDLE: begin
        if (accept) begin
          tex_d    = (in_item_i.func == sbtsb_pkg::FUNC_TEX);
          handle_d = in_item_i.texture_handle;
          slot_d   = '0;
          append_d = 1'b0;
          issue_d  = SW'(1);
          rd_vld_d = 1'b0;
          unique case (in_item_i.func)
            sbtsb_pkg::FUNC_BEGIN: begin
              slots_used_d = SW'(1);
              quad_count_d = '0;
            end
            sbtsb_pkg::FUNC_CLR_STS: begin
              flush_cnt_d = '0;
              quad_cnt_d  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      sbtsb_pkg::ST_END_FLUSH: begin
        if (out_free_i) begin
          res_o.push      = 1'b1;
          res_o.item      = flush_item;
          res_o.item.last = 1'b1;
          flush_cnt_d     = flush_inc;
        end
      end
      sbtsb_pkg::ST_QUAD_FLUSH: begin
        if (out_free_i) begin
          res_o.push   = 1'b1;
          res_o.item   = flush_item;
          flush_cnt_d  = flush_inc;
          slots_used_d = SW'(1);
          quad_count_d = '0;
        end
      end
      sbtsb_pkg::ST_SEARCH: begin
        priority if (white_hit) begin
          slot_d   = '0;
          rd_vld_d = 1'b0;
        end else if (tbl_hit) begin
          slot_d   = rd_idx_q;
          rd_vld_d = 1'b0;
        end else if (can_issue) begin
          ram_re   = 1'b1;
          rd_idx_d = issue_q[AW-1:0];
          rd_vld_d = 1'b1;
          issue_d  = issue_q + SW'(1);
        end else if (rd_vld_q) begin
          rd_vld_d = 1'b0;
        end else begin
          append_d = 1'b1;
          slot_d   = slots_full ? AW'(1) : slots_used_q[AW-1:0];
        end
      end
      sbtsb_pkg::ST_SLOT_FLUSH: begin
        if (!batch_empty && out_free_i) begin
          res_o.push  = 1'b1;
          res_o.item  = flush_item;
          flush_cnt_d = flush_inc;
        end
        if (batch_empty || out_free_i) begin
          slots_used_d = SW'(1);
          quad_count_d = '0;
        end
      end
      sbtsb_pkg::ST_PLACE: begin
        if (out_free_i) begin
          res_o.push   = 1'b1;
          res_o.item   = quad_item;
          quad_count_d = quad_count_q + QW'(1);
          quad_cnt_d   = quad_inc;
          if (append_q) begin
            ram_we       = 1'b1;
            slots_used_d = slots_used_q + SW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= sbtsb_pkg::ST_IDLE;
      rd_vld_q     <= 1'b0;
      slots_used_q <= SW'(1);
      quad_count_q <= '0;
      flush_cnt_q  <= '0;
      quad_cnt_q   <= '0;
    end else begin
      state_q      <= state_d;
      rd_vld_q     <= rd_vld_d;
      slots_used_q <= slots_used_d;
      quad_count_q <= quad_count_d;
      flush_cnt_q  <= flush_cnt_d;
      quad_cnt_q   <= quad_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tex_q    <= tex_d;
    handle_q <= handle_d;
    slot_q   <= slot_d;
    append_q <= append_d;
    issue_q  <= issue_d;
    rd_idx_q <= rd_idx_d;
  end

  `SBTSB_ASSERT_NOW(a_slots_range, clk_i, rst_ni, 1'b1,
    (slots_used_q != '0) && (slots_used_q <= SW'(MaxSlots)), "slot count out of range")
  `SBTSB_ASSERT_NOW(a_push_free, clk_i, rst_ni, res_o.push, out_free_i,
    "result pushed into a busy output register")
  `SBTSB_ASSERT_NOW(a_quad_pos, clk_i, rst_ni,
    res_o.push && (res_o.item.kind == sbtsb_pkg::KIND_QUAD),
    quad_count_q < QW'(MaxQuads), "quad placed in a full batch")
  `SBTSB_ASSERT_NEXT(a_append_grows, clk_i, rst_ni,
    (state_q == sbtsb_pkg::ST_PLACE) && out_free_i && append_q,
    slots_used_q == $past(slots_used_q) + SW'(1), "appended slot not counted")

endmodule

// ----- design/sprite_batch_texture_slot_binder_unit.sv -----
// Top level of the sprite batch texture slot binder.
// Depends on sbtsb_pkg, sbtsb_apb, sbtsb_out and sbtsb_ctrl.
//
// Usage: commands enter on the in channel (in_valid_i, in_stall_o, in_item_i)
// and results leave on the out channel (out_valid_o, out_stall_i, out_item_o);
// an item moves when valid is high and stall is low. Each command yields zero,
// one or two result items; the last one carries last = 1.
// The user is to write the white texture handle over the APB-style port only
// while idle; the block does not enforce it. One command is worked on at a
// time. Begin scene, clear statistics and end scene on an empty batch are done
// in the idle state. An untextured quad goes to the place state, which pushes
// its result into the output register. A textured quad scans the slot table
// memory one entry per cycle, set by the single read port of that memory, over
// the slots in use up to a match. Each flush result is pushed by a flush state.
// Reset empties the batch (slot zero only), clears the draw-call and quad
// counters and the white handle; the slot table needs no clearing.
// A stalled receiver holds the result in the output register; the block
// still takes the next command and waits only when it has a new result ready.
module sprite_batch_texture_slot_binder_unit #(
  parameter int unsigned MaxQuads = sbtsb_pkg::MAX_QUADS,
  parameter int unsigned MaxSlots = sbtsb_pkg::MAX_SLOTS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sbtsb_pkg::in_item_t   in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sbtsb_pkg::out_item_t  out_item_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [31:0]     white;
  logic            out_free;
  sbtsb_pkg::res_t res;

  sbtsb_apb u_apb (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .white_o(white)
  );

  sbtsb_ctrl #(
    .MaxQuads(MaxQuads),
    .MaxSlots(MaxSlots)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_item_i (in_item_i),
    .white_i   (white),
    .out_free_i(out_free),
    .res_o     (res)
  );

  sbtsb_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_i      (res),
    .free_o     (out_free),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule
